[hdl/sdet_pkg.sv]
package sdet_pkg;

   localparam int unsigned TIME_W = 32;
   localparam int unsigned LIMIT_W = 16;
   localparam int unsigned CSR_ADDR_W = 4;
   localparam int unsigned CSR_DATA_W = 32;
   localparam int unsigned REQ_DATA_W = 40;
   localparam int unsigned RSP_DATA_W = 72;

   localparam logic [LIMIT_W-1:0] MIN_ON_RESET = 16'd30;
   localparam logic [LIMIT_W-1:0] MIN_OFF_RESET = 16'd30;

   typedef enum logic [1:0] {
      REG_INVERTED_MODE = 2'd0,
      REG_MIN_ON_MS     = 2'd1,
      REG_MIN_OFF_MS    = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic                 inverted_mode;
      logic [LIMIT_W-1:0]   min_on_ms;
      logic [LIMIT_W-1:0]   min_off_ms;
   } config_type;

   typedef struct packed {
      logic [TIME_W-1:0] released_duration;
      logic [TIME_W-1:0] pressed_duration;
      logic              release_edge;
      logic              press_edge;
      logic              debounced_pressed;
   } result_type;

endpackage

[hdl/switch_debounce_edge_timer_unit.sv]
// Channel   Direction  Contents
// req_      in         request: pin level and millisecond timestamp
// rsp_      out        debounced state, edge pulses, phase durations
// csr_      in/out     APB registers: inverted mode, minimum on and off times
//
// One request is taken every cycle while no result is stalled on rsp_tready.
// Its result is computed combinationally and registered, appearing in the next cycle.
// A result waiting on rsp_tready holds, and a new request is taken in the cycle it leaves.
// Synchronous reset restores the released phase and the register defaults.
module switch_debounce_edge_timer_unit (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // [0] pin_level, [32:1] time_ms, [39:33] zero
   input  logic [sdet_pkg::REQ_DATA_W-1:0]     req_tdata,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // [0] debounced_pressed, [1] press_edge, [2] release_edge,
   // [34:3] pressed_duration, [66:35] released_duration, [71:67] zero
   output logic [sdet_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [sdet_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [sdet_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [sdet_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                                csr_pready
);

   localparam int unsigned RESULT_W = $bits(sdet_pkg::result_type);

   sdet_pkg::config_type   cfg_ff;
   sdet_pkg::result_type   result;
   sdet_pkg::result_type   rsp_data_ff;
   logic                   rsp_valid_ff;
   logic                   req_accept;
   logic                   csr_write;
   logic [1:0]             csr_index;

   assign csr_pready = 1'b1;
   assign csr_write = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign csr_index = csr_paddr[3:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.inverted_mode <= 1'b0;
         cfg_ff.min_on_ms <= sdet_pkg::MIN_ON_RESET;
         cfg_ff.min_off_ms <= sdet_pkg::MIN_OFF_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            sdet_pkg::REG_INVERTED_MODE: cfg_ff.inverted_mode <= csr_pwdata[0];
            sdet_pkg::REG_MIN_ON_MS:
               cfg_ff.min_on_ms <= csr_pwdata[sdet_pkg::LIMIT_W-1:0];
            sdet_pkg::REG_MIN_OFF_MS:
               cfg_ff.min_off_ms <= csr_pwdata[sdet_pkg::LIMIT_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         sdet_pkg::REG_INVERTED_MODE:
            csr_prdata = {{(sdet_pkg::CSR_DATA_W-1){1'b0}}, cfg_ff.inverted_mode};
         sdet_pkg::REG_MIN_ON_MS:
            csr_prdata = {{(sdet_pkg::CSR_DATA_W-sdet_pkg::LIMIT_W){1'b0}},
                          cfg_ff.min_on_ms};
         sdet_pkg::REG_MIN_OFF_MS:
            csr_prdata = {{(sdet_pkg::CSR_DATA_W-sdet_pkg::LIMIT_W){1'b0}},
                          cfg_ff.min_off_ms};
         default: csr_prdata = '0;
      endcase
   end

   assign req_tready = ~rsp_valid_ff | rsp_tready;
   assign req_accept = req_tvalid & req_tready;

   sdet_phase_fsm u_phase_fsm (
      .clock     (clock),
      .reset     (reset),
      .step      (req_accept),
      .pin_level (req_tdata[0]),
      .time_ms   (req_tdata[sdet_pkg::TIME_W:1]),
      .cfg       (cfg_ff),
      .result    (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = {{(sdet_pkg::RSP_DATA_W-RESULT_W){1'b0}}, rsp_data_ff};

endmodule

[hdl/sdet_phase_fsm.sv]
module sdet_phase_fsm (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                step,
   input  logic                                pin_level,
   input  logic [sdet_pkg::TIME_W-1:0]         time_ms,
   input  sdet_pkg::config_type                cfg,
   output sdet_pkg::result_type                result
);

   typedef enum logic [1:0] {
      PH_RELEASED     = 2'd0,
      PH_PEND_PRESS   = 2'd1,
      PH_PRESSED      = 2'd2,
      PH_PEND_RELEASE = 2'd3
   } phase_type;

   phase_type                    phase_ff, phase_in;
   logic [sdet_pkg::TIME_W-1:0]  press_start_ff, press_start_in;
   logic [sdet_pkg::TIME_W-1:0]  release_start_ff, release_start_in;
   logic                         pressed_ff, pressed_in;
   logic                         press_pulse_ff, press_pulse_in;
   logic                         release_pulse_ff, release_pulse_in;
   logic [sdet_pkg::TIME_W-1:0]  press_len_ff, press_len_in;
   logic [sdet_pkg::TIME_W-1:0]  release_len_ff, release_len_in;
   logic                         active;
   logic [sdet_pkg::TIME_W-1:0]  since_press;
   logic [sdet_pkg::TIME_W-1:0]  since_release;
   logic [sdet_pkg::TIME_W-1:0]  on_limit;
   logic [sdet_pkg::TIME_W-1:0]  off_limit;

   assign active = cfg.inverted_mode ? pin_level : ~pin_level;
   assign since_press = time_ms - press_start_ff;
   assign since_release = time_ms - release_start_ff;
   assign on_limit = {{(sdet_pkg::TIME_W-sdet_pkg::LIMIT_W){1'b0}}, cfg.min_on_ms};
   assign off_limit = {{(sdet_pkg::TIME_W-sdet_pkg::LIMIT_W){1'b0}}, cfg.min_off_ms};

   always_comb begin
      phase_in = phase_ff;
      press_start_in = press_start_ff;
      release_start_in = release_start_ff;
      pressed_in = pressed_ff;
      press_pulse_in = press_pulse_ff;
      release_pulse_in = release_pulse_ff;
      press_len_in = press_len_ff;
      release_len_in = release_len_ff;
      unique case (phase_ff)
         PH_RELEASED: begin
            release_pulse_in = 1'b0;
            if (active) begin
               press_start_in = time_ms;
               phase_in = PH_PEND_PRESS;
            end else begin
               release_len_in = since_release;
            end
         end
         PH_PEND_PRESS: begin
            if (!active) begin
               phase_in = PH_RELEASED;
            end else if (since_press > on_limit) begin
               phase_in = PH_PRESSED;
               pressed_in = 1'b1;
               press_pulse_in = 1'b1;
               release_len_in = press_start_ff - release_start_ff;
            end
         end
         PH_PRESSED: begin
            press_pulse_in = 1'b0;
            if (!active) begin
               release_start_in = time_ms;
               phase_in = PH_PEND_RELEASE;
            end else begin
               press_len_in = since_press;
            end
         end
         PH_PEND_RELEASE: begin
            if (active) begin
               phase_in = PH_PRESSED;
            end else if (since_release > off_limit) begin
               phase_in = PH_RELEASED;
               pressed_in = 1'b0;
               release_pulse_in = 1'b1;
               press_len_in = release_start_ff - press_start_ff;
            end
         end
         default: begin
            phase_in = PH_RELEASED;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_RELEASED;
         press_start_ff <= '0;
         release_start_ff <= '0;
         pressed_ff <= 1'b0;
         press_pulse_ff <= 1'b0;
         release_pulse_ff <= 1'b0;
         press_len_ff <= '0;
         release_len_ff <= '0;
      end else if (step) begin
         phase_ff <= phase_in;
         press_start_ff <= press_start_in;
         release_start_ff <= release_start_in;
         pressed_ff <= pressed_in;
         press_pulse_ff <= press_pulse_in;
         release_pulse_ff <= release_pulse_in;
         press_len_ff <= press_len_in;
         release_len_ff <= release_len_in;
      end
   end

   assign result.debounced_pressed = pressed_in;
   assign result.press_edge = press_pulse_in;
   assign result.release_edge = release_pulse_in;
   assign result.pressed_duration = press_len_in;
   assign result.released_duration = release_len_in;

endmodule

[hdl/sdet_checker.sv]
module sdet_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_tvalid,
   input logic                             req_tready,
   input logic                             rsp_tvalid,
   input logic                             rsp_tready,
   input logic [sdet_pkg::RSP_DATA_W-1:0]  rsp_tdata
);

   // A confirmed press always reports the pressed state.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[1]) |-> rsp_tdata[0])
      else $error("press edge without pressed state");

   // A confirmed release always reports the released state.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[2]) |-> !rsp_tdata[0])
      else $error("release edge with pressed state");

   // A request taken always yields a result in the following cycle.
   assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> rsp_tvalid)
      else $error("request produced no result");

   // A stalled result holds its data.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)))
      else $error("stalled result changed");

endmodule

bind switch_debounce_edge_timer_unit sdet_checker u_sdet_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
